/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of the bit field buffer.
// No dependencies; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication; cons may open with a constant delay.
`define BFB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("bfb check failed");

// Next-cycle implication.
`define BFB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfb check failed");

`endif

/* rtl/core/bfb_pkg.sv */
// Shared constants, codes and stage control type of the MSB-first bit field buffer.
// No dependencies; the design and checker files refer to it by scoped names, the bench imports it.
package bfb_pkg;

  // Sizes
  localparam int STORE_BYTES_DEF = 256;
  localparam int MAX_FIELD_BITS  = 32;
  localparam int WORD_BITS       = 32;
  localparam int POS_W           = 12;
  localparam int POS_LIMIT       = 1 << POS_W;
  localparam int CAP_RESET_DEF   = 2048;
  localparam int CFG_W           = 12;
  localparam int CFG_IDX_W       = 1;
  localparam int FW_W            = 6;
  localparam int OFF_W           = 5;
  localparam int STATUS_W        = 3;

  // Commands
  localparam logic [1:0] CMD_PUT     = 2'd0;
  localparam logic [1:0] CMD_GET     = 2'd1;
  localparam logic [1:0] CMD_SEEK    = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERRUN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_WIDTH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SEEK_PAST = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_EXPAND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b1;

  // Control carried from the decode stage to the merge stage
  typedef struct packed {
    logic                valid;
    logic                put_ok;
    logic                get_ok;
    logic                w0_odd;
    logic [OFF_W-1:0]    off;
    logic [OFF_W-1:0]    rshift;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    cursor;
    logic [POS_W-1:0]    window_end;
  } s2_ctrl_t;

endpackage

/* rtl/core/bfb_bank.sv */
// One bank of the bit store: 32-bit words, one write and one registered read a cycle.
// Depends on bfb_pkg for the word width.
module bfb_bank #(
  parameter int DEPTH = bfb_pkg::STORE_BYTES_DEF / 8,
  parameter int AW    = 5
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [bfb_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [bfb_pkg::WORD_BITS-1:0] rdata
);

  logic [bfb_pkg::WORD_BITS-1:0] mem [DEPTH];

  // Write and read the word array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bfb_ctrl.sv */
// Input register, configuration registers, cursor/window state and command decode.
// Depends on bfb_pkg; feeds read rows to the banks and stage control to bfb_merge.
module bfb_ctrl #(
  parameter int STORE_BYTES = bfb_pkg::STORE_BYTES_DEF,
  parameter int ROW_AW      = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      cmd,
  input  logic [bfb_pkg::FW_W-1:0]        field_width,
  input  logic [bfb_pkg::WORD_BITS-1:0]   field_value,
  input  logic [bfb_pkg::POS_W-1:0]       seek_target,
  input  logic                            cfg_write,
  input  logic [bfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfb_pkg::CFG_W-1:0]       cfg_data,
  output logic [ROW_AW-1:0]               rd_row_even,
  output logic [ROW_AW-1:0]               rd_row_odd,
  output bfb_pkg::s2_ctrl_t               s2,
  output logic [ROW_AW-1:0]               s2_row_even,
  output logic [ROW_AW-1:0]               s2_row_odd,
  output logic [2*bfb_pkg::WORD_BITS-1:0] s2_data,
  output logic [2*bfb_pkg::WORD_BITS-1:0] s2_mask
);

  localparam int STORE_BITS = STORE_BYTES * 8;
  localparam int STORE_CAP  = (STORE_BITS < bfb_pkg::POS_LIMIT) ? STORE_BITS
                                                               : bfb_pkg::POS_LIMIT;
  localparam int CAP_RESET  = (STORE_CAP < bfb_pkg::CAP_RESET_DEF) ? STORE_CAP
                                                                  : bfb_pkg::CAP_RESET_DEF;
  localparam int PW  = bfb_pkg::POS_W;
  localparam int WAW = bfb_pkg::POS_W - bfb_pkg::OFF_W;
  localparam int WB  = bfb_pkg::WORD_BITS;

  // Input register
  logic                     in_valid;
  logic [1:0]               in_cmd;
  logic [bfb_pkg::FW_W-1:0] in_width;
  logic [WB-1:0]            in_value;
  logic [PW-1:0]            in_target;

  // Configuration and window state
  logic          auto_expand;
  logic [PW-1:0] capacity_bits;
  logic [PW-1:0] cursor, cursor_next;
  logic [PW-1:0] window_end, window_end_next;

  // Decode
  logic                         width_ok;
  logic [PW:0]                  need;
  logic [PW:0]                  eff_cap;
  logic                         past_end;
  logic                         expand_ok;
  logic [bfb_pkg::STATUS_W-1:0] status_c;
  logic                         put_ok, get_ok;
  logic [WAW-1:0]               w0;
  logic [WAW-1:0]               row_even_w;
  logic [bfb_pkg::OFF_W-1:0]    rshift;
  logic [WB-1:0]                lj_value, lj_mask;

  // Check width, end and capacity
  always_comb begin
    width_ok  = (in_width != '0) &&
                (in_width <= bfb_pkg::FW_W'(bfb_pkg::MAX_FIELD_BITS));
    need      = {1'b0, cursor} + (PW+1)'(in_width);
    eff_cap   = ({1'b0, capacity_bits} < (PW+1)'(STORE_CAP)) ? {1'b0, capacity_bits}
                                                            : (PW+1)'(STORE_CAP);
    past_end  = need > {1'b0, window_end};
    expand_ok = auto_expand && (need <= eff_cap);
  end

  // Decide the command's effect on cursor and window end
  always_comb begin
    cursor_next     = cursor;
    window_end_next = window_end;
    status_c        = bfb_pkg::ST_OK;
    put_ok          = 1'b0;
    get_ok          = 1'b0;
    if (in_valid) begin
      case (in_cmd)
        bfb_pkg::CMD_PUT: begin
          if (!width_ok) begin
            status_c = bfb_pkg::ST_BAD_WIDTH;
          end else if (past_end && !expand_ok) begin
            status_c = bfb_pkg::ST_OVERFLOW;
          end else begin
            put_ok      = 1'b1;
            cursor_next = need[PW-1:0];
            if (past_end) begin
              window_end_next = need[PW-1:0];
            end
          end
        end
        bfb_pkg::CMD_GET: begin
          if (!width_ok) begin
            status_c = bfb_pkg::ST_BAD_WIDTH;
          end else if (past_end) begin
            status_c = bfb_pkg::ST_UNDERRUN;
          end else begin
            get_ok      = 1'b1;
            cursor_next = need[PW-1:0];
          end
        end
        bfb_pkg::CMD_SEEK: begin
          if (in_target > window_end) begin
            status_c = bfb_pkg::ST_SEEK_PAST;
          end else begin
            cursor_next = in_target;
          end
        end
        bfb_pkg::CMD_RESTART: begin
          cursor_next     = '0;
          window_end_next = auto_expand ? '0 : eff_cap[PW-1:0];
        end
        default: begin
          status_c = bfb_pkg::ST_OK;
        end
      endcase
    end
  end

  // Address the two words under the cursor and align the field
  always_comb begin
    w0          = cursor[PW-1:bfb_pkg::OFF_W];
    row_even_w  = WAW'(w0[WAW-1:1]) + WAW'(w0[0]);
    rd_row_odd  = ROW_AW'(w0[WAW-1:1]);
    rd_row_even = ROW_AW'(row_even_w);
    rshift      = bfb_pkg::OFF_W'(bfb_pkg::FW_W'(WB) - in_width);
    lj_value    = in_value << rshift;
    lj_mask     = {WB{1'b1}} << rshift;
  end

  // Capture items, update state, hand control to the merge stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      auto_expand   <= 1'b0;
      capacity_bits <= PW'(bfb_pkg::CAP_RESET_DEF);
      cursor        <= '0;
      window_end    <= PW'(CAP_RESET);
      s2            <= '0;
    end else begin
      in_valid   <= accept;
      cursor     <= cursor_next;
      window_end <= window_end_next;
      if (cfg_write) begin
        case (cfg_index)
          bfb_pkg::REG_AUTO_EXPAND: auto_expand   <= cfg_data[0];
          bfb_pkg::REG_CAPACITY:    capacity_bits <= cfg_data;
          default:                  auto_expand   <= auto_expand;
        endcase
      end
      s2.valid      <= in_valid;
      s2.put_ok     <= put_ok;
      s2.get_ok     <= get_ok;
      s2.w0_odd     <= w0[0];
      s2.off        <= cursor[bfb_pkg::OFF_W-1:0];
      s2.rshift     <= rshift;
      s2.status     <= status_c;
      s2.cursor     <= cursor_next;
      s2.window_end <= window_end_next;
    end
  end

  // Item payload and field alignment, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd    <= cmd;
      in_width  <= field_width;
      in_value  <= field_value;
      in_target <= seek_target;
    end
    s2_row_even <= rd_row_even;
    s2_row_odd  <= rd_row_odd;
    s2_data     <= {lj_value, {WB{1'b0}}} >> cursor[bfb_pkg::OFF_W-1:0];
    s2_mask     <= {lj_mask, {WB{1'b0}}} >> cursor[bfb_pkg::OFF_W-1:0];
  end

endmodule

/* rtl/core/bfb_merge.sv */
// Merge stage: bypass of the last write, field insert/extract, bank writes, result register.
// Also runs the clearing sweep after reset. Depends on bfb_pkg.
module bfb_merge #(
  parameter int BANK_DEPTH = bfb_pkg::STORE_BYTES_DEF / 8,
  parameter int ROW_AW     = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bfb_pkg::s2_ctrl_t               s2,
  input  logic [ROW_AW-1:0]               row_even,
  input  logic [ROW_AW-1:0]               row_odd,
  input  logic [2*bfb_pkg::WORD_BITS-1:0] fdata,
  input  logic [2*bfb_pkg::WORD_BITS-1:0] fmask,
  input  logic [bfb_pkg::WORD_BITS-1:0]   rdata_even,
  input  logic [bfb_pkg::WORD_BITS-1:0]   rdata_odd,
  output logic                            we_even,
  output logic                            we_odd,
  output logic [ROW_AW-1:0]               waddr_even,
  output logic [ROW_AW-1:0]               waddr_odd,
  output logic [bfb_pkg::WORD_BITS-1:0]   wdata_even,
  output logic [bfb_pkg::WORD_BITS-1:0]   wdata_odd,
  output logic                            clearing,
  output logic                            done,
  output logic [bfb_pkg::WORD_BITS-1:0]   read_value,
  output logic [bfb_pkg::STATUS_W-1:0]    status,
  output logic [bfb_pkg::POS_W-1:0]       cursor_position,
  output logic [bfb_pkg::POS_W-1:0]       bits_left,
  output logic [bfb_pkg::POS_W-1:0]       window_length
);

  localparam int WB = bfb_pkg::WORD_BITS;

  logic [ROW_AW-1:0] clear_row;

  // Last item write per bank, for a read sampled on the same edge
  logic              fwd_even_valid, fwd_odd_valid;
  logic [ROW_AW-1:0] fwd_even_row, fwd_odd_row;
  logic [WB-1:0]     fwd_even_data, fwd_odd_data;

  logic [WB-1:0]   even_old, odd_old;
  logic [2*WB-1:0] win, win_new, rd_shift;
  logic [WB-1:0]   rd_field;
  logic [WB-1:0]   new_even, new_odd, mask_even, mask_odd;
  logic            itm_we_even, itm_we_odd;

  // Pick current words, bypassing the write of the previous edge
  always_comb begin
    even_old = (fwd_even_valid && (fwd_even_row == row_even)) ? fwd_even_data : rdata_even;
    odd_old  = (fwd_odd_valid && (fwd_odd_row == row_odd)) ? fwd_odd_data : rdata_odd;
    win      = s2.w0_odd ? {odd_old, even_old} : {even_old, odd_old};
  end

  // Insert the field for a put, extract it for a get
  always_comb begin
    win_new   = (win & ~fmask) | (fdata & fmask);
    new_even  = s2.w0_odd ? win_new[WB-1:0] : win_new[2*WB-1:WB];
    new_odd   = s2.w0_odd ? win_new[2*WB-1:WB] : win_new[WB-1:0];
    mask_even = s2.w0_odd ? fmask[WB-1:0] : fmask[2*WB-1:WB];
    mask_odd  = s2.w0_odd ? fmask[2*WB-1:WB] : fmask[WB-1:0];
    itm_we_even = s2.valid && s2.put_ok && (mask_even != '0);
    itm_we_odd  = s2.valid && s2.put_ok && (mask_odd != '0);
    rd_shift  = win << s2.off;
    rd_field  = rd_shift[2*WB-1:WB] >> s2.rshift;
  end

  // Drive the bank write ports, zeros while clearing
  always_comb begin
    we_even    = clearing || itm_we_even;
    we_odd     = clearing || itm_we_odd;
    waddr_even = clearing ? clear_row : row_even;
    waddr_odd  = clearing ? clear_row : row_odd;
    wdata_even = clearing ? '0 : new_even;
    wdata_odd  = clearing ? '0 : new_odd;
  end

  // Sweep every row once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      if (clear_row == ROW_AW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_row <= clear_row + 1'b1;
      end
    end
  end

  // Hold the write of this edge for the bypass, and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_even_valid <= 1'b0;
      fwd_odd_valid  <= 1'b0;
      done           <= 1'b0;
    end else begin
      fwd_even_valid <= itm_we_even;
      fwd_odd_valid  <= itm_we_odd;
      done           <= s2.valid;
    end
  end

  // Result payload and bypass data
  always_ff @(posedge clk) begin
    fwd_even_row    <= row_even;
    fwd_odd_row     <= row_odd;
    fwd_even_data   <= new_even;
    fwd_odd_data    <= new_odd;
    read_value      <= s2.get_ok ? rd_field : '0;
    status          <= s2.status;
    cursor_position <= s2.cursor;
    bits_left       <= s2.window_end - s2.cursor;
    window_length   <= s2.window_end;
  end

endmodule

/* rtl/core/msb_first_bit_field_buffer_unit.sv */
// Top level of the MSB-first bit field buffer: decode, two word banks, merge stage.
// Depends on bfb_pkg, bfb_ctrl, bfb_bank and bfb_merge.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------------
//   command   start / busy         cmd, field_width, field_value, seek_target
//   result    done (one cycle)     read_value, status, cursor_position,
//                                  bits_left, window_length
//   config    cfg_write            cfg_index, cfg_data
//
// One item is taken every cycle while busy is low; its result strobes done after
// the input register, decode with bank read and merge with bank write.
// A put/get covers two adjacent 32-bit words, one per bank, so one item needs
// a single read and at most a single write on each bank port.
// After rst, busy stays high while every row of both banks is swept to zero;
// configuration writes are taken throughout.
// The result side has no back-pressure: done is never held off.
module msb_first_bit_field_buffer_unit #(
  parameter int STORE_BYTES = bfb_pkg::STORE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [bfb_pkg::FW_W-1:0]      field_width,
  input  logic [bfb_pkg::WORD_BITS-1:0] field_value,
  input  logic [bfb_pkg::POS_W-1:0]     seek_target,
  output logic                          done,
  output logic [bfb_pkg::WORD_BITS-1:0] read_value,
  output logic [bfb_pkg::STATUS_W-1:0]  status,
  output logic [bfb_pkg::POS_W-1:0]     cursor_position,
  output logic [bfb_pkg::POS_W-1:0]     bits_left,
  output logic [bfb_pkg::POS_W-1:0]     window_length,
  input  logic                          cfg_write,
  input  logic [bfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int BANK_DEPTH = (STORE_BYTES + 7) / 8;
  localparam int ROW_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int WB         = bfb_pkg::WORD_BITS;

  logic                accept;
  logic [ROW_AW-1:0]   rd_row_even, rd_row_odd;
  bfb_pkg::s2_ctrl_t   s2;
  logic [ROW_AW-1:0]   s2_row_even, s2_row_odd;
  logic [2*WB-1:0]     s2_data, s2_mask;
  logic [WB-1:0]       rdata_even, rdata_odd;
  logic                we_even, we_odd;
  logic [ROW_AW-1:0]   waddr_even, waddr_odd;
  logic [WB-1:0]       wdata_even, wdata_odd;
  logic                clearing;

  // Take an item whenever the banks are not being cleared
  assign busy   = clearing;
  assign accept = start && !busy;

  bfb_ctrl #(
    .STORE_BYTES (STORE_BYTES),
    .ROW_AW      (ROW_AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .field_width (field_width),
    .field_value (field_value),
    .seek_target (seek_target),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rd_row_even (rd_row_even),
    .rd_row_odd  (rd_row_odd),
    .s2          (s2),
    .s2_row_even (s2_row_even),
    .s2_row_odd  (s2_row_odd),
    .s2_data     (s2_data),
    .s2_mask     (s2_mask)
  );

  bfb_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (ROW_AW)
  ) u_bank_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr_even),
    .wdata (wdata_even),
    .raddr (rd_row_even),
    .rdata (rdata_even)
  );

  bfb_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (ROW_AW)
  ) u_bank_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr_odd),
    .wdata (wdata_odd),
    .raddr (rd_row_odd),
    .rdata (rdata_odd)
  );

  bfb_merge #(
    .BANK_DEPTH (BANK_DEPTH),
    .ROW_AW     (ROW_AW)
  ) u_merge (
    .clk             (clk),
    .rst             (rst),
    .s2              (s2),
    .row_even        (s2_row_even),
    .row_odd         (s2_row_odd),
    .fdata           (s2_data),
    .fmask           (s2_mask),
    .rdata_even      (rdata_even),
    .rdata_odd       (rdata_odd),
    .we_even         (we_even),
    .we_odd          (we_odd),
    .waddr_even      (waddr_even),
    .waddr_odd       (waddr_odd),
    .wdata_even      (wdata_even),
    .wdata_odd       (wdata_odd),
    .clearing        (clearing),
    .done            (done),
    .read_value      (read_value),
    .status          (status),
    .cursor_position (cursor_position),
    .bits_left       (bits_left),
    .window_length   (window_length)
  );

endmodule

/* rtl/core/bfb_checker.sv */
// Port-level checks of the bit field buffer, bound to the top level.
// Depends on assert_macros.svh and bfb_pkg.
`include "assert_macros.svh"

module bfb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [bfb_pkg::WORD_BITS-1:0] read_value,
  input logic [bfb_pkg::STATUS_W-1:0]  status,
  input logic [bfb_pkg::POS_W-1:0]     cursor_position,
  input logic [bfb_pkg::POS_W-1:0]     bits_left,
  input logic [bfb_pkg::POS_W-1:0]     window_length
);

  // Every accepted item gives a result on done, and done comes only for an accepted item
  `BFB_ASSERT_IMPL(a_result_follows, clk, rst, start && !busy, ##3 done)
  `BFB_ASSERT_IMPL(a_result_has_item, clk, rst, done, ($past(start && !busy, 3)))

  // Window arithmetic stays consistent
  `BFB_ASSERT_IMPL(a_window_sum, clk, rst, done,
                   (bfb_pkg::POS_W'(cursor_position + bits_left) == window_length))

  // A failed command returns no data
  `BFB_ASSERT_IMPL(a_fail_no_data, clk, rst, done && (status != bfb_pkg::ST_OK),
                   (read_value == '0))

  // Once clearing ends, busy stays low until the next reset
  `BFB_ASSERT_NEXT(a_busy_once, clk, rst, !busy, !busy)

endmodule

bind msb_first_bit_field_buffer_unit bfb_checker u_bfb_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .read_value      (read_value),
  .status          (status),
  .cursor_position (cursor_position),
  .bits_left       (bits_left),
  .window_length   (window_length)
);

/* tb/msb_first_bit_field_buffer_unit_test.sv */
// Self-checking bench for the MSB-first bit field buffer: directed items, then random phases.
// Every result is checked against a behavioral shadow of the store, cursor and window end, or a typed row's value.
// Depends on bfb_pkg and msb_first_bit_field_buffer_unit.
module msb_first_bit_field_buffer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bfb_pkg::*;

  localparam int STORE_BITS    = STORE_BYTES_DEF * 8;
  localparam int STALL_LIMIT   = 400;
  localparam int PHASE_ITEMS   = 72;
  localparam int RANDOM_PHASES = 9;

  typedef struct packed {
    logic [1:0]           op;
    logic [FW_W-1:0]      width;
    logic [WORD_BITS-1:0] value;
    logic [POS_W-1:0]     target;
  } field_cmd_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_value;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     cursor;
    logic [POS_W-1:0]     remaining;
    logic [POS_W-1:0]     window;
  } field_result_t;

  typedef struct {
    bit                   reg_write;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     reg_data;
    field_cmd_t           item;
    bit                   typed;
    field_result_t        want;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           cmd;
  logic [FW_W-1:0]      field_width;
  logic [WORD_BITS-1:0] field_value;
  logic [POS_W-1:0]     seek_target;
  logic                 done;
  logic [WORD_BITS-1:0] read_value;
  logic [STATUS_W-1:0]  status;
  logic [POS_W-1:0]     cursor_position;
  logic [POS_W-1:0]     bits_left;
  logic [POS_W-1:0]     window_length;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Shadow of the block: bit array, cursor, window end and registers
  bit                   shadow_bits [STORE_BITS];
  int unsigned          cur_pos;
  int unsigned          win_end;
  bit                   expand_on;
  logic [CFG_W-1:0]     cap_reg;

  field_result_t        awaited_results [$];
  plan_row_t            directed_plan [$];
  int                   mismatch_count;

  msb_first_bit_field_buffer_unit dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .field_width     (field_width),
    .field_value     (field_value),
    .seek_target     (seek_target),
    .done            (done),
    .read_value      (read_value),
    .status          (status),
    .cursor_position (cursor_position),
    .bits_left       (bits_left),
    .window_length   (window_length),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one item to the shadow state and return the result it should give
  function automatic field_result_t next_field_result(field_cmd_t it);
    field_result_t r;
    int unsigned   n;
    int unsigned   need;
    int unsigned   limit;
    int unsigned   p;
    int unsigned   i;
    r = '0;
    r.status = ST_OK;
    n = it.width;
    limit = (cap_reg < STORE_BITS) ? cap_reg : STORE_BITS;
    case (it.op)
      CMD_PUT: begin
        if (n < 1 || n > MAX_FIELD_BITS) begin
          r.status = ST_BAD_WIDTH;
        end else begin
          need = cur_pos + n;
          if (need > win_end) begin
            if (expand_on && need <= limit) win_end = need;
            else r.status = ST_OVERFLOW;
          end
          if (r.status == ST_OK) begin
            for (i = 0; i < n; i++) begin
              p = cur_pos + i;
              if (p < STORE_BITS) shadow_bits[p] = it.value[n - 1 - i];
            end
            cur_pos = need;
          end
        end
      end
      CMD_GET: begin
        if (n < 1 || n > MAX_FIELD_BITS) begin
          r.status = ST_BAD_WIDTH;
        end else if (cur_pos + n > win_end) begin
          r.status = ST_UNDERRUN;
        end else begin
          for (i = 0; i < n; i++) begin
            p = cur_pos + i;
            r.read_value = {r.read_value[WORD_BITS-2:0], (p < STORE_BITS) ? shadow_bits[p] : 1'b0};
          end
          cur_pos = cur_pos + n;
        end
      end
      CMD_SEEK: begin
        if (it.target > win_end) r.status = ST_SEEK_PAST;
        else cur_pos = it.target;
      end
      CMD_RESTART: begin
        cur_pos = 0;
        win_end = expand_on ? 0 : limit;
      end
      default: begin
        r.status = ST_OK;
      end
    endcase
    r.cursor    = cur_pos[POS_W-1:0];
    r.remaining = POS_W'(win_end - cur_pos);
    r.window    = win_end[POS_W-1:0];
    return r;
  endfunction

  // Random item, mostly well-formed; seeks land inside the current window most of the time
  function automatic field_cmd_t random_item();
    field_cmd_t  it;
    int unsigned pick;
    it.op     = CMD_PUT;
    it.width  = FW_W'($urandom_range(1, MAX_FIELD_BITS));
    it.value  = $urandom();
    it.target = POS_W'($urandom_range(0, POS_LIMIT - 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      it.op    = pick[0] ? CMD_PUT : CMD_GET;
      it.width = (pick < 2) ? '0 : FW_W'($urandom_range(MAX_FIELD_BITS + 1, 63));
    end else if (pick < 40) begin
      it.op = CMD_PUT;
    end else if (pick < 72) begin
      it.op = CMD_GET;
    end else if (pick < 94) begin
      it.op = CMD_SEEK;
      if ($urandom_range(0, 4) != 0) it.target = POS_W'($urandom_range(0, win_end));
    end else begin
      it.op    = CMD_RESTART;
      it.width = FW_W'($urandom_range(0, 63));
    end
    return it;
  endfunction

  function automatic field_cmd_t make_item(logic [1:0] op, logic [FW_W-1:0] w,
                                           logic [WORD_BITS-1:0] v, logic [POS_W-1:0] t);
    field_cmd_t it;
    it.op     = op;
    it.width  = w;
    it.value  = v;
    it.target = t;
    return it;
  endfunction

  // Table builders
  function automatic void add_item(logic [1:0] op, logic [FW_W-1:0] w,
                                   logic [WORD_BITS-1:0] v, logic [POS_W-1:0] t);
    plan_row_t row;
    row = '{default: '0};
    row.item = make_item(op, w, v, t);
    directed_plan.push_back(row);
  endfunction

  function automatic void add_typed(logic [1:0] op, logic [FW_W-1:0] w,
                                    logic [WORD_BITS-1:0] v, logic [POS_W-1:0] t,
                                    logic [WORD_BITS-1:0] rv, logic [STATUS_W-1:0] st,
                                    logic [POS_W-1:0] cur, logic [POS_W-1:0] rem,
                                    logic [POS_W-1:0] win);
    plan_row_t row;
    row = '{default: '0};
    row.item  = make_item(op, w, v, t);
    row.typed = 1'b1;
    row.want  = '{read_value: rv, status: st, cursor: cur, remaining: rem, window: win};
    directed_plan.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.reg_write = 1'b1;
    row.reg_index = idx;
    row.reg_data  = data;
    directed_plan.push_back(row);
  endfunction

  // Present one item, hold it until accepted, then record what it should produce
  task automatic send_item(field_cmd_t it, bit typed, field_result_t want);
    field_result_t predicted;
    start       <= 1'b1;
    cmd         <= it.op;
    field_width <= it.width;
    field_value <= it.value;
    seek_target <= it.target;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = next_field_result(it);
    awaited_results.push_back(typed ? want : predicted);
  endtask

  // Drop start for a random burst, pct percent of the time
  task automatic maybe_idle(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stop issuing and wait until every outstanding item has reported
  task automatic drain();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_AUTO_EXPAND) expand_on = data[0];
    else cap_reg = data;
    @(posedge clk);
  endtask

  function automatic void check_field(string tag, logic [WORD_BITS-1:0] want,
                                      logic [WORD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, tag, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin : result_check
    field_result_t want;
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, status expected none actual %0h",
                 $time, status);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("read_value", want.read_value, read_value);
        check_field("status", want.status, status);
        check_field("cursor_position", want.cursor, cursor_position);
        check_field("bits_left", want.remaining, bits_left);
        check_field("window_length", want.window, window_length);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int            ph;
    int            k;
    int            gap_pct;
    bit            ae;
    logic [CFG_W-1:0] cap;
    field_result_t unused;
    start          = 1'b0;
    cmd            = CMD_PUT;
    field_width    = '0;
    field_value    = '0;
    seek_target    = '0;
    cfg_write      = 1'b0;
    cfg_index      = REG_AUTO_EXPAND;
    cfg_data       = '0;
    rst            = 1'b1;
    mismatch_count = 0;
    unused         = '0;

    // Shadow state as after reset
    foreach (shadow_bits[k]) shadow_bits[k] = 1'b0;
    expand_on = 1'b0;
    cap_reg   = CFG_W'(CAP_RESET_DEF);
    cur_pos   = 0;
    win_end   = CAP_RESET_DEF;

    // Reset registers: full window, no expansion
    add_typed(CMD_GET, 0, 0, 0, 0, ST_BAD_WIDTH, 0, 2048, 2048);
    add_typed(CMD_PUT, 33, 32'hFFFF_FFFF, 0, 0, ST_BAD_WIDTH, 0, 2048, 2048);
    add_typed(CMD_GET, 32, 0, 0, 0, ST_OK, 32, 2016, 2048);
    add_typed(CMD_SEEK, 0, 0, 2048, 0, ST_OK, 2048, 0, 2048);
    add_typed(CMD_GET, 1, 0, 0, 0, ST_UNDERRUN, 2048, 0, 2048);
    add_typed(CMD_PUT, 1, 1, 0, 0, ST_OVERFLOW, 2048, 0, 2048);
    add_typed(CMD_SEEK, 0, 0, 4095, 0, ST_SEEK_PAST, 2048, 0, 2048);
    add_typed(CMD_SEEK, 0, 0, 0, 0, ST_OK, 0, 2048, 2048);
    add_typed(CMD_PUT, 32, 32'hFFFF_FFFF, 0, 0, ST_OK, 32, 2016, 2048);
    // Unaligned puts into set bits, value bits above the width ignored
    add_item(CMD_SEEK, 0, 0, 5);
    add_item(CMD_PUT, 13, 32'hA5A5_A5A5, 0);
    add_item(CMD_PUT, 7, 32'hFFFF_FF80, 0);
    add_item(CMD_SEEK, 0, 0, 3);
    add_item(CMD_GET, 24, 0, 0);
    // Last word of the store
    add_item(CMD_SEEK, 0, 0, 2016);
    add_item(CMD_PUT, 32, 32'h8000_0001, 0);
    add_item(CMD_SEEK, 0, 0, 2016);
    add_item(CMD_GET, 32, 0, 0);
    add_typed(CMD_RESTART, 0, 32'hFFFF_FFFF, 4095, 0, ST_OK, 0, 2048, 2048);
    // Expanding window against a small capacity
    add_reg(REG_AUTO_EXPAND, 1);
    add_reg(REG_CAPACITY, 40);
    add_typed(CMD_RESTART, 0, 0, 0, 0, ST_OK, 0, 0, 0);
    add_item(CMD_PUT, 32, 32'hFFFF_FFFF, 0);
    add_typed(CMD_PUT, 9, 32'h1FF, 0, 0, ST_OVERFLOW, 32, 0, 32);
    add_item(CMD_PUT, 8, 32'h5A, 0);
    // Capacity above the store is clamped
    add_reg(REG_AUTO_EXPAND, 0);
    add_reg(REG_CAPACITY, 4095);
    add_typed(CMD_RESTART, 0, 0, 0, 0, ST_OK, 0, 2048, 2048);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_plan[k]) begin
      if (directed_plan[k].reg_write) begin
        drain();
        write_reg(directed_plan[k].reg_index, directed_plan[k].reg_data);
      end else begin
        send_item(directed_plan[k].item, directed_plan[k].typed, directed_plan[k].want);
        maybe_idle(25);
      end
    end

    // Random phases, each under its own register setting
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin ae = 1'b0; cap = 12'd2048; end
        1: begin ae = 1'b1; cap = 12'd2048; end
        2: begin ae = 1'b0; cap = 12'd0; end
        3: begin ae = 1'b1; cap = 12'd4095; end
        4: begin ae = 1'b0; cap = 12'd4095; end
        5: begin ae = 1'b1; cap = 12'd0; end
        6: begin ae = 1'b1; cap = CFG_W'($urandom_range(1, 2047)); end
        7: begin ae = 1'b0; cap = CFG_W'($urandom_range(1, 2047)); end
        default: begin
          ae  = 1'($urandom_range(0, 1));
          cap = CFG_W'($urandom_range(0, 4095));
        end
      endcase
      write_reg(REG_AUTO_EXPAND, {(CFG_W-1)'($urandom()), ae});
      write_reg(REG_CAPACITY, cap);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 45;
      endcase
      if (ph == RANDOM_PHASES - 1) gap_pct = 0;
      // Usually restart so the window follows the new registers; sometimes keep the old one
      if ($urandom_range(0, 3) != 0)
        send_item(make_item(CMD_RESTART, FW_W'($urandom_range(0, 63)), $urandom(),
                            POS_W'($urandom_range(0, POS_LIMIT - 1))), 1'b0, unused);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_item(random_item(), 1'b0, unused);
        maybe_idle(gap_pct);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bfb_pkg.sv
rtl/core/bfb_bank.sv
rtl/core/bfb_ctrl.sv
rtl/core/bfb_merge.sv
rtl/core/msb_first_bit_field_buffer_unit.sv
rtl/core/bfb_checker.sv
tb/msb_first_bit_field_buffer_unit_test.sv
